FILE: hdl/iss_pkg.sv
`timescale 1ns / 1ps

package iss_pkg;

  localparam int VALUE_BITS = 32;
  localparam int POS_BITS   = 10;
  localparam int COUNT_BITS = 11;
  localparam int CODE_BITS  = 3;

  localparam logic [CODE_BITS-1:0] OP_PUSH  = 3'd0;
  localparam logic [CODE_BITS-1:0] OP_POP   = 3'd1;
  localparam logic [CODE_BITS-1:0] OP_READ  = 3'd2;
  localparam logic [CODE_BITS-1:0] OP_WRITE = 3'd3;
  localparam logic [CODE_BITS-1:0] OP_FIND  = 3'd4;
  localparam logic [CODE_BITS-1:0] OP_CLEAR = 3'd5;

  localparam logic [CODE_BITS-1:0] STS_OK       = 3'd0;
  localparam logic [CODE_BITS-1:0] STS_EMPTY    = 3'd1;
  localparam logic [CODE_BITS-1:0] STS_RANGE    = 3'd2;
  localparam logic [CODE_BITS-1:0] STS_NOTFOUND = 3'd3;
  localparam logic [CODE_BITS-1:0] STS_FULL     = 3'd4;

  typedef struct packed {
    logic [CODE_BITS-1:0]  operation;
    logic [POS_BITS-1:0]   position;
    logic [VALUE_BITS-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] result_value;
    logic [POS_BITS-1:0]   found_position;
    logic [COUNT_BITS-1:0] element_count;
    logic [CODE_BITS-1:0]  status;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDWAIT,
    S_SCAN,
    S_HOLD
  } state_t;

endpackage

FILE: hdl/iss_if.sv
`timescale 1ns / 1ps

interface iss_in_if;
  logic             valid;
  logic             ready;
  iss_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface iss_out_if;
  logic               valid;
  logic               ready;
  iss_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/iss_mem.sv
`timescale 1ns / 1ps

module iss_mem #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [VALUE_WIDTH-1:0]       wdata,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [VALUE_WIDTH-1:0]       rdata
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/iss_ctrl.sv
`timescale 1ns / 1ps

module iss_ctrl #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  iss_in_if.sink                   in_ch,
  output logic                     res_valid,
  output iss_pkg::out_item_t       res_data,
  input  logic                     res_ready,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [VALUE_WIDTH-1:0]   mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [VALUE_WIDTH-1:0]   mem_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int CNTB = iss_pkg::COUNT_BITS;
  localparam int POSB = iss_pkg::POS_BITS;
  localparam int VALB = iss_pkg::VALUE_BITS;

  iss_pkg::state_t    state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      scan_idx, scan_idx_next;
  logic [AW-1:0]      cmp_idx, cmp_idx_next;
  logic               cmp_valid, cmp_valid_next;
  logic [VALUE_WIDTH-1:0] key, key_next;
  iss_pkg::out_item_t hold, hold_next;

  logic [2:0]  op;
  logic [31:0] pos32, cnt32, inc32, scan32, fpos32;
  logic [63:0] val_wide, rd_wide;
  logic [VALUE_WIDTH-1:0] wval;
  logic        pos_ok, full, empty, multi, in_ready;

  assign in_ch.ready = in_ready;

  always_comb begin
    op       = in_ch.data.operation;
    pos32    = 32'(in_ch.data.position);
    cnt32    = 32'(count);
    inc32    = cnt32 + 32'd1;
    scan32   = 32'(scan_idx);
    fpos32   = 32'(cmp_idx);
    val_wide = 64'(in_ch.data.operand_value);
    wval     = val_wide[VALUE_WIDTH-1:0];
    rd_wide  = 64'(mem_rdata);
    pos_ok   = pos32 < cnt32;
    full     = cnt32 >= DEPTH;
    empty    = cnt32 == 32'd0;
    multi    = (op == iss_pkg::OP_FIND) || ((op == iss_pkg::OP_POP) && !empty) ||
               ((op == iss_pkg::OP_READ) && pos_ok);

    state_next     = state;
    count_next     = count;
    scan_idx_next  = scan_idx;
    cmp_idx_next   = cmp_idx;
    cmp_valid_next = cmp_valid;
    key_next       = key;
    hold_next      = hold;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = wval;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    res_data.result_value   = '0;
    res_data.found_position = '0;
    res_data.element_count  = cnt32[CNTB-1:0];
    res_data.status         = iss_pkg::STS_OK;

    unique case (state)
      iss_pkg::S_IDLE: begin
        in_ready = res_ready || multi;
        if (in_ch.valid && in_ready) begin
          case (op)
            iss_pkg::OP_PUSH: begin
              res_valid = 1'b1;
              if (full) begin
                res_data.status = iss_pkg::STS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count);
                count_next = count + CW'(1);
                res_data.element_count = inc32[CNTB-1:0];
              end
            end
            iss_pkg::OP_POP: begin
              if (empty) begin
                res_valid = 1'b1;
                res_data.status = iss_pkg::STS_EMPTY;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(count - CW'(1));
                count_next = count - CW'(1);
                state_next = iss_pkg::S_RDWAIT;
              end
            end
            iss_pkg::OP_READ: begin
              if (!pos_ok) begin
                res_valid = 1'b1;
                res_data.status = iss_pkg::STS_RANGE;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(in_ch.data.position);
                state_next = iss_pkg::S_RDWAIT;
              end
            end
            iss_pkg::OP_WRITE: begin
              res_valid = 1'b1;
              if (!pos_ok) begin
                res_data.status = iss_pkg::STS_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_ch.data.position);
              end
            end
            iss_pkg::OP_FIND: begin
              key_next       = wval;
              scan_idx_next  = '0;
              cmp_valid_next = 1'b0;
              state_next     = iss_pkg::S_SCAN;
            end
            iss_pkg::OP_CLEAR: begin
              res_valid  = 1'b1;
              count_next = '0;
              res_data.element_count = '0;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      iss_pkg::S_RDWAIT: begin
        res_valid = 1'b1;
        res_data.result_value = rd_wide[VALB-1:0];
        if (res_ready) begin
          state_next = iss_pkg::S_IDLE;
        end
      end
      iss_pkg::S_SCAN: begin
        if (cmp_valid && (mem_rdata == key)) begin
          hold_next.result_value   = '0;
          hold_next.found_position = fpos32[POSB-1:0];
          hold_next.element_count  = cnt32[CNTB-1:0];
          hold_next.status         = iss_pkg::STS_OK;
          state_next = iss_pkg::S_HOLD;
        end else if (!cmp_valid && (scan32 >= cnt32)) begin
          hold_next.result_value   = '0;
          hold_next.found_position = '0;
          hold_next.element_count  = cnt32[CNTB-1:0];
          hold_next.status         = iss_pkg::STS_NOTFOUND;
          state_next = iss_pkg::S_HOLD;
        end else if (scan32 < cnt32) begin
          mem_re         = 1'b1;
          mem_raddr      = AW'(scan_idx);
          cmp_idx_next   = AW'(scan_idx);
          cmp_valid_next = 1'b1;
          scan_idx_next  = scan_idx + CW'(1);
        end else begin
          cmp_valid_next = 1'b0;
        end
      end
      iss_pkg::S_HOLD: begin
        res_valid = 1'b1;
        res_data  = hold;
        if (res_ready) begin
          state_next = iss_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = iss_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= iss_pkg::S_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cmp_valid <= cmp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    cmp_idx  <= cmp_idx_next;
    key      <= key_next;
    hold     <= hold_next;
  end

endmodule

FILE: hdl/indexed_stack_store.sv
`timescale 1ns / 1ps

// Bounded stack of DEPTH entries with indexed read/write, linear find and
// clear. One result item per input item, held in an output register.
// Push, write, clear, unused codes and a failing pop or read are answered
// straight from the idle state; pop and read add the registered read of the
// entry memory. Find walks the live entries through a single comparator, one
// memory read per cycle, until a match or the end of the live entries.
// Clear only resets the count. The block takes no new item while a pop, read or
// find is in progress; while a result item waits in a full output register it
// takes only a find, a pop of a non-empty store or an in-range read.
module indexed_stack_store #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  iss_in_if.sink    in_ch,
  iss_out_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);

  logic                   res_valid, res_ready;
  iss_pkg::out_item_t     res_data;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;
  logic                   out_valid;
  iss_pkg::out_item_t     out_data;

  iss_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  iss_mem #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready    = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_data;
    end
  end

endmodule

FILE: tb/sv/stack_store_checker.sv
`timescale 1ns / 1ps

module stack_store_checker #(
  parameter int DEPTH = 1024
) (
  input  logic clk,
  input  logic rst,
  iss_in_if    req,
  iss_out_if   rsp,
  output int   errors,
  output int   outstanding,
  output int   checked
);
  import iss_pkg::*;

  logic [VALUE_BITS-1:0] shadow_entries [DEPTH];
  int unsigned           shadow_level;
  out_item_t             pending_results [$];
  int                    mismatches = 0;
  int                    compared = 0;

  function automatic out_item_t apply_stack_op(in_item_t it);
    out_item_t   r;
    int unsigned i;
    bit          hit;
    r = '0;
    r.status = STS_OK;
    hit = 1'b0;
    case (it.operation)
      OP_PUSH: begin
        if (shadow_level >= DEPTH) begin
          r.status = STS_FULL;
        end else begin
          shadow_entries[shadow_level] = it.operand_value;
          shadow_level++;
        end
      end
      OP_POP: begin
        if (shadow_level == 0) begin
          r.status = STS_EMPTY;
        end else begin
          shadow_level--;
          r.result_value = shadow_entries[shadow_level];
        end
      end
      OP_READ: begin
        if (it.position >= shadow_level) begin
          r.status = STS_RANGE;
        end else begin
          r.result_value = shadow_entries[it.position];
        end
      end
      OP_WRITE: begin
        if (it.position >= shadow_level) begin
          r.status = STS_RANGE;
        end else begin
          shadow_entries[it.position] = it.operand_value;
        end
      end
      OP_FIND: begin
        r.status = STS_NOTFOUND;
        for (i = 0; i < shadow_level && !hit; i++) begin
          if (shadow_entries[i] == it.operand_value) begin
            hit = 1'b1;
            r.found_position = POS_BITS'(i);
            r.status = STS_OK;
          end
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < shadow_level; i++) begin
          shadow_entries[i] = '0;
        end
        shadow_level = 0;
      end
      default: begin
      end
    endcase
    r.element_count = COUNT_BITS'(shadow_level);
    return r;
  endfunction

  // results first: the block never answers an item in the cycle it takes it
  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    if (rst) begin
      shadow_level = 0;
      pending_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = rsp.data;
        if (pending_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected result: value %h pos %0d count %0d status %0d",
                     $realtime, got.result_value, got.found_position,
                     got.element_count, got.status);
          end
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compared++;
          if (got.result_value !== want.result_value ||
              got.found_position !== want.found_position ||
              got.element_count !== want.element_count ||
              got.status !== want.status) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch: expected value %h pos %0d count %0d status %0d",
                       $realtime, want.result_value, want.found_position,
                       want.element_count, want.status);
              $display("%0t:           got      value %h pos %0d count %0d status %0d",
                       $realtime, got.result_value, got.found_position,
                       got.element_count, got.status);
            end
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_results.insert(pending_results.size(), apply_stack_op(req.data));
      end
    end
    errors      <= mismatches;
    outstanding <= pending_results.size();
    checked     <= compared;
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import iss_pkg::*;

  localparam int DEPTH  = 1024;
  localparam int LIMIT  = 12_000_000;
  localparam int SETTLE = 16;
  localparam logic [CODE_BITS-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [CODE_BITS-1:0] OP_SPARE_HI = 3'd7;

  logic clk;
  logic rst;
  bit   calm;
  int   fill = 0;
  int   peak_fill = 0;
  int   full_hits = 0;
  int   sent = 0;
  int   op_seen [8];
  int   cycles = 0;
  int   errors;
  int   outstanding;
  int   checked;

  iss_in_if  in_ch ();
  iss_out_if out_ch ();

  indexed_stack_store #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stack_store_checker #(
    .DEPTH (DEPTH)
  ) store_check (
    .clk         (clk),
    .rst         (rst),
    .req         (in_ch),
    .rsp         (out_ch),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_item_t cmd(logic [CODE_BITS-1:0] op, int pos,
                                   logic [VALUE_BITS-1:0] val);
    in_item_t it;
    it.operation     = op;
    it.position      = POS_BITS'(pos);
    it.operand_value = val;
    return it;
  endfunction

  // small pool so that finds hit and duplicates occur
  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return VALUE_BITS'($urandom_range(1, 7));
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [POS_BITS-1:0] pick_position();
    if (fill > 0 && $urandom_range(0, 3) != 0) begin
      return POS_BITS'($urandom_range(0, fill - 1));
    end
    return POS_BITS'($urandom_range(0, 2**POS_BITS - 1));
  endfunction

  function automatic in_item_t draw_item(bit filling);
    in_item_t it;
    int       roll;
    roll = $urandom_range(0, 99);
    it.position      = pick_position();
    it.operand_value = pick_value();
    if (filling) begin
      if (roll < 90) it.operation = OP_PUSH;
      else if (roll < 92) it.operation = OP_POP;
      else if (roll < 95) it.operation = OP_READ;
      else if (roll < 97) it.operation = OP_WRITE;
      else if (roll < 99) it.operation = OP_FIND;
      else it.operation = OP_SPARE_LO;
    end else begin
      if (roll < 35) it.operation = OP_PUSH;
      else if (roll < 47) it.operation = OP_POP;
      else if (roll < 63) it.operation = OP_READ;
      else if (roll < 76) it.operation = OP_WRITE;
      else if (roll < 92) it.operation = OP_FIND;
      else if (roll < 95) it.operation = OP_CLEAR;
      else if (roll < 97) it.operation = OP_SPARE_LO;
      else it.operation = OP_SPARE_HI;
    end
    return it;
  endfunction

  task automatic send(input in_item_t it);
    int gap;
    if (sent % 50 == 0) calm <= ($urandom_range(0, 4) == 0);
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    op_seen[it.operation]++;
    case (it.operation)
      OP_PUSH: begin
        if (fill < DEPTH) fill++;
        else full_hits++;
      end
      OP_POP: begin
        if (fill > 0) fill--;
      end
      OP_CLEAR: begin
        fill = 0;
      end
      default: begin
      end
    endcase
    if (fill > peak_fill) peak_fill = fill;
  endtask

  initial begin : result_side
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : stimulus
    int n;
    rst         <= 1'b1;
    calm        <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    foreach (op_seen[k]) op_seen[k] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty store, unused codes, then a short stack with duplicates
    send(cmd(OP_POP, 0, '0));
    send(cmd(OP_READ, 0, '0));
    send(cmd(OP_WRITE, 2**POS_BITS - 1, '1));
    send(cmd(OP_FIND, 0, '0));
    send(cmd(OP_SPARE_LO, 5, '1));
    send(cmd(OP_SPARE_HI, 2**POS_BITS - 1, '0));
    send(cmd(OP_PUSH, 0, '0));
    send(cmd(OP_PUSH, 0, '1));
    send(cmd(OP_PUSH, 0, 32'h5A5A_5A5A));
    send(cmd(OP_PUSH, 0, '1));
    send(cmd(OP_FIND, 0, '1));
    send(cmd(OP_FIND, 0, '0));
    send(cmd(OP_FIND, 0, 32'h0001_2345));
    send(cmd(OP_READ, 3, '0));
    send(cmd(OP_READ, 4, '0));
    send(cmd(OP_WRITE, 2, 32'hA5A5_A5A5));
    send(cmd(OP_WRITE, 4, 32'h1111_1111));
    send(cmd(OP_READ, 2, '0));
    send(cmd(OP_READ, 2**POS_BITS - 1, '0));
    send(cmd(OP_POP, 0, '0));
    send(cmd(OP_SPARE_LO, 0, '0));
    send(cmd(OP_CLEAR, 0, '0));
    send(cmd(OP_POP, 0, '0));
    send(cmd(OP_PUSH, 0, 32'h8000_0001));
    send(cmd(OP_POP, 0, '0));

    for (n = 0; n < 420; n++) send(draw_item(1'b0));

    // fill to the brim, then work on the full store
    while (fill < DEPTH) send(draw_item(1'b1));
    send(cmd(OP_PUSH, 0, pick_value()));
    send(cmd(OP_FIND, 0, 32'h1234_5678));
    send(cmd(OP_READ, DEPTH - 1, '0));
    send(cmd(OP_WRITE, DEPTH - 1, 32'hC3C3_3C3C));
    send(cmd(OP_FIND, 0, 32'hC3C3_3C3C));
    send(cmd(OP_POP, 0, '0));
    send(cmd(OP_PUSH, 0, '1));
    send(cmd(OP_PUSH, 0, '0));
    send(cmd(OP_SPARE_HI, 0, '0));
    send(cmd(OP_CLEAR, 0, '0));

    for (n = 0; n < 100; n++) send(draw_item(1'b0));

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (SETTLE) @(posedge clk);

    $display("run: %0d items: %0d push, %0d pop, %0d read, %0d write,",
             sent, op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_READ],
             op_seen[OP_WRITE]);
    $display("run: %0d find, %0d clear, %0d unused; %0d results checked",
             op_seen[OP_FIND], op_seen[OP_CLEAR],
             op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_HI], checked);
    $display("run: peak fill %0d of %0d, %0d pushes refused as full",
             peak_fill, DEPTH, full_hits);
    if (errors == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: indexed_stack_store.f
hdl/iss_pkg.sv
hdl/iss_if.sv
hdl/iss_mem.sv
hdl/iss_ctrl.sv
hdl/indexed_stack_store.sv
tb/sv/stack_store_checker.sv
tb/sv/tb.sv
